// File: src/tpz_pkg.sv
// Shared types and constants for the torus point projector with depth buffer.
// Holds the request and result beats, datapath word formats and register codes.
// No dependencies.
package tpz_pkg;

  localparam int CO_W = 24;
  localparam int OPB_W = 17;
  localparam int ACC_W = 44;
  localparam int FRAC = 14;
  localparam int DEN_W = 32;
  localparam int QW = 9;
  localparam int SHADE_SHIFT = 11;

  localparam logic [3:0] BLANK_CODE = 4'd12;
  localparam logic [3:0] SHADE_MAX = 4'd11;
  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;
  localparam logic signed [OPB_W-1:0] INV_SQRT2 = 17'sd11585;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_PLOT = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [2:0] REG_COS_TILT = 3'd0;
  localparam logic [2:0] REG_SIN_TILT = 3'd1;
  localparam logic [2:0] REG_COS_SPIN = 3'd2;
  localparam logic [2:0] REG_SIN_SPIN = 3'd3;
  localparam logic [2:0] REG_TUBE_RADIUS = 3'd4;
  localparam logic [2:0] REG_RING_RADIUS = 3'd5;
  localparam logic [2:0] REG_VIEW_DISTANCE = 3'd6;
  localparam logic [2:0] REG_PROJ_SCALE = 3'd7;

  typedef logic signed [CO_W-1:0] coord_t;
  typedef logic signed [OPB_W-1:0] opb_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [15:0] cos_tube;
    logic signed [15:0] sin_tube;
    logic signed [15:0] cos_ring;
    logic signed [15:0] sin_ring;
    logic [5:0] read_row;
    logic [5:0] read_col;
  } request_t;

  typedef struct packed {
    logic [3:0] shade_code;
    logic [5:0] pixel_row;
    logic [5:0] pixel_col;
    logic written;
    logic dropped;
  } result_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic sub;
  } mac_op_t;

  typedef struct packed {
    logic done;
    logic ovf;
    logic neg;
    logic [QW-1:0] quot;
  } div_res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_RD, S_RDW,
    S_PX, S_PY, S_X1, S_Z1, S_Y2A, S_Y2B, S_Z2A, S_Z2B,
    S_XA, S_XB, S_YA, S_YB, S_NXT,
    S_LM, S_CN1, S_CN2, S_CDIV, S_CWAIT, S_RN2, S_RDIV, S_RWAIT,
    S_PRD, S_PWB
  } state_t;

endpackage

// File: src/tpz_mac.sv
// Shared multiply-accumulate unit with round-to-nearest Q1.14 rescaling.
// Depends on tpz_pkg.
module tpz_mac import tpz_pkg::*; (
  input  logic    clk,
  input  mac_op_t op,
  input  coord_t  a,
  input  opb_t    b,
  output acc_t    acc,
  output coord_t  rnd
);

  logic signed [CO_W+OPB_W-1:0] prod;
  acc_t prod_ext;
  acc_t rnd_sum;

  assign prod = a * b;
  assign prod_ext = acc_t'(prod);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= (op.clear ? acc_t'(0) : acc) + (op.sub ? -prod_ext : prod_ext);
    end
  end

  // Adding half an LSB and shifting gives ties toward plus infinity.
  assign rnd_sum = acc + acc_t'(1 << (FRAC - 1));
  assign rnd = rnd_sum[FRAC+CO_W-1:FRAC];

endmodule

// File: src/tpz_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Reports an overflow when the quotient needs more than QW bits. Depends on tpz_pkg.
module tpz_div import tpz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  acc_t             num,
  input  logic [DEN_W-1:0] den,
  output div_res_t         res
);

  localparam int CNT_W = $clog2(QW + 1);

  logic running;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] dsh;
  logic [ACC_W-1:0] abs_num;
  logic [QW-1:0] quot;
  logic ovf;
  logic neg;

  assign abs_num = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= CNT_W'(QW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= num[ACC_W-1];
      mag <= abs_num;
      dsh <= ACC_W'(den) << (QW - 1);
      ovf <= abs_num >= (ACC_W'(den) << QW);
      quot <= '0;
    end else if (running) begin
      if (mag >= dsh) begin
        mag <= mag - dsh;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        quot <= {quot[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign res = '{done: done, ovf: ovf, neg: neg, quot: quot};

endmodule

// File: src/torus_point_project_zbuffer.sv
// Torus surface point projector with a shade and depth frame store.
// A clear sweeps every frame-store address and a read fetches one word; a plot has one shared
// multiply-accumulate step through 27 products and a one-bit-per-cycle divider
// run twice. One request at a time; the result beat follows the last step.
// Synchronous reset restores the registers and then sweeps the whole frame store,
// during which busy is high.
module torus_point_project_zbuffer import tpz_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int NPIX = ROWS * COLS;
  localparam int AW = $clog2(NPIX);

  logic signed [15:0] cos_tilt, sin_tilt, cos_spin, sin_spin;
  logic [10:0] tube_radius, ring_radius;
  logic [12:0] view_distance;
  logic [15:0] proj_scale;

  state_t state, state_next;
  logic pass;
  logic clr_report;
  logic [AW-1:0] clr_addr;
  request_t req;

  coord_t px, py, x1, z1, y2;
  coord_t pt_x, pt_y, pt_z, nm_x, nm_y, nm_z, lum;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  mac_op_t mac_op;
  coord_t mac_a;
  opb_t mac_b;
  acc_t acc;
  coord_t rnd;

  logic div_go;
  logic [DEN_W-1:0] div_den;
  div_res_t div_res;

  logic [19:0] mem [NPIX];
  logic [19:0] mem_q;
  logic [19:0] mem_wdata;
  logic [AW-1:0] mem_addr;
  logic mem_we;

  logic done_next;
  result_t res_next;
  result_t blank_res;

  logic col_ok, row_ok, rd_ok, win;
  logic [3:0] sh4;
  logic [15:0] zq;
  logic [CO_W-1-SHADE_SHIFT:0] sh_full;

  tpz_mac u_mac (
    .clk(clk), .op(mac_op), .a(mac_a), .b(mac_b), .acc(acc), .rnd(rnd)
  );

  assign div_den = DEN_W'({pt_z, 8'd0});

  tpz_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(acc), .den(div_den), .res(div_res)
  );

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_tilt <= 16'sd16384;
      sin_tilt <= 16'sd0;
      cos_spin <= 16'sd16384;
      sin_spin <= 16'sd0;
      tube_radius <= 11'd512;
      ring_radius <= 11'd1024;
      view_distance <= 13'd5120;
      proj_scale <= 16'd16000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COS_TILT: cos_tilt <= pwdata[15:0];
        REG_SIN_TILT: sin_tilt <= pwdata[15:0];
        REG_COS_SPIN: cos_spin <= pwdata[15:0];
        REG_SIN_SPIN: sin_spin <= pwdata[15:0];
        REG_TUBE_RADIUS: tube_radius <= pwdata[10:0];
        REG_RING_RADIUS: ring_radius <= pwdata[10:0];
        REG_VIEW_DISTANCE: view_distance <= pwdata[12:0];
        REG_PROJ_SCALE: proj_scale <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COS_TILT: prdata = 32'(cos_tilt);
      REG_SIN_TILT: prdata = 32'(sin_tilt);
      REG_COS_SPIN: prdata = 32'(cos_spin);
      REG_SIN_SPIN: prdata = 32'(sin_spin);
      REG_TUBE_RADIUS: prdata = 32'(tube_radius);
      REG_RING_RADIUS: prdata = 32'(ring_radius);
      REG_VIEW_DISTANCE: prdata = 32'(view_distance);
      REG_PROJ_SCALE: prdata = 32'(proj_scale);
    endcase
  end

  // Frame store: shade code in the top nibble, depth below.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  // A negative numerator whose magnitude is below the denominator truncates to zero.
  assign col_ok = !div_res.ovf && (!div_res.neg || div_res.quot == '0) &&
                  div_res.quot < QW'(COLS);
  assign row_ok = !div_res.ovf && (!div_res.neg || div_res.quot == '0) &&
                  div_res.quot < QW'(ROWS);
  assign rd_ok = (9'(req.read_row) < 9'(ROWS)) && (9'(req.read_col) < 9'(COLS));

  assign sh_full = lum[CO_W-1:SHADE_SHIFT];
  assign sh4 = (sh_full > (CO_W-SHADE_SHIFT)'(SHADE_MAX)) ? SHADE_MAX
                                                           : sh_full[3:0];
  assign zq = (pt_z > coord_t'(DEPTH_MAX)) ? DEPTH_MAX : pt_z[15:0];
  assign win = !lum[CO_W-1] && (mem_q[15:0] > zq);

  assign blank_res = '{shade_code: BLANK_CODE, pixel_row: 6'd0, pixel_col: 6'd0,
                       written: 1'b0, dropped: 1'b0};

  always_comb begin
    state_next = state;
    mac_op = '0;
    mac_a = '0;
    mac_b = '0;
    div_go = 1'b0;
    mem_we = 1'b0;
    mem_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
    mem_wdata = {sh4, zq};
    done_next = 1'b0;
    res_next = blank_res;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.req_type)
            REQ_CLEAR: state_next = S_CLR;
            REQ_PLOT: state_next = S_PX;
            REQ_READ: state_next = S_RD;
            default: done_next = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        mem_addr = clr_addr;
        mem_we = 1'b1;
        mem_wdata = {BLANK_CODE, DEPTH_MAX};
        if (clr_addr == AW'(NPIX - 1)) begin
          state_next = S_IDLE;
          done_next = clr_report;
        end
      end
      S_RD: begin
        mem_addr = AW'(req.read_row) * AW'(COLS) + AW'(req.read_col);
        if (rd_ok) begin
          state_next = S_RDW;
        end else begin
          state_next = S_IDLE;
          done_next = 1'b1;
          res_next.pixel_row = req.read_row;
          res_next.pixel_col = req.read_col;
          res_next.dropped = 1'b1;
        end
      end
      S_RDW: begin
        state_next = S_IDLE;
        done_next = 1'b1;
        res_next.shade_code = mem_q[19:16];
        res_next.pixel_row = req.read_row;
        res_next.pixel_col = req.read_col;
      end
      S_PX: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = coord_t'(tube_radius);
        mac_b = opb_t'(req.cos_tube);
        state_next = S_PY;
      end
      S_PY: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = coord_t'(tube_radius);
        mac_b = opb_t'(req.sin_tube);
        state_next = S_X1;
      end
      S_X1: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = (pass) ? px : px;
        mac_b = opb_t'(req.cos_ring);
        state_next = S_Z1;
      end
      S_Z1: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = px;
        mac_b = opb_t'(req.sin_ring);
        state_next = S_Y2A;
      end
      S_Y2A: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = py;
        mac_b = opb_t'(cos_tilt);
        state_next = S_Y2B;
      end
      S_Y2B: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b1};
        mac_a = z1;
        mac_b = opb_t'(sin_tilt);
        state_next = S_Z2A;
      end
      S_Z2A: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = py;
        mac_b = opb_t'(sin_tilt);
        state_next = S_Z2B;
      end
      S_Z2B: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0};
        mac_a = z1;
        mac_b = opb_t'(cos_tilt);
        state_next = S_XA;
      end
      S_XA: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = x1;
        mac_b = opb_t'(cos_spin);
        state_next = S_XB;
      end
      S_XB: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b1};
        mac_a = y2;
        mac_b = opb_t'(sin_spin);
        state_next = S_YA;
      end
      S_YA: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = x1;
        mac_b = opb_t'(sin_spin);
        state_next = S_YB;
      end
      S_YB: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0};
        mac_a = y2;
        mac_b = opb_t'(cos_spin);
        state_next = S_NXT;
      end
      S_NXT: begin
        // The first pass rotates the point, the second one the normal.
        state_next = pass ? S_LM : S_X1;
      end
      S_LM: begin
        if (pt_z[CO_W-1] || pt_z == '0) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          res_next.dropped = 1'b1;
        end else begin
          mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
          mac_a = nm_x + nm_y;
          mac_b = INV_SQRT2;
          state_next = S_CN1;
        end
      end
      S_CN1: begin
        mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
        mac_a = pt_x;
        mac_b = $signed({1'b0, proj_scale});
        state_next = S_CN2;
      end
      S_CN2: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0};
        mac_a = pt_z;
        mac_b = OPB_W'(COLS * 128);
        state_next = S_CDIV;
      end
      S_CDIV: begin
        div_go = 1'b1;
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        if (div_res.done) begin
          if (col_ok) begin
            mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b1};
            mac_a = pt_y;
            mac_b = $signed({1'b0, proj_scale});
            state_next = S_RN2;
          end else begin
            state_next = S_IDLE;
            done_next = 1'b1;
            res_next.dropped = 1'b1;
          end
        end
      end
      S_RN2: begin
        mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0};
        mac_a = pt_z;
        mac_b = OPB_W'(ROWS * 128);
        state_next = S_RDIV;
      end
      S_RDIV: begin
        div_go = 1'b1;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_res.done) begin
          if (row_ok) begin
            state_next = S_PRD;
          end else begin
            state_next = S_IDLE;
            done_next = 1'b1;
            res_next.dropped = 1'b1;
          end
        end
      end
      S_PRD: begin
        state_next = S_PWB;
      end
      S_PWB: begin
        mem_we = win;
        state_next = S_IDLE;
        done_next = 1'b1;
        res_next.shade_code = win ? sh4 : mem_q[19:16];
        res_next.pixel_row = 6'(row_q);
        res_next.pixel_col = 6'(col_q);
        res_next.written = win;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      clr_report <= 1'b0;
      pass <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      if (state == S_IDLE) begin
        pass <= 1'b0;
        clr_addr <= '0;
        clr_report <= 1'b1;
      end else if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_NXT) begin
        pass <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (state == S_IDLE && start) begin
      req <= request;
    end
    unique case (state)
      S_PY: px <= coord_t'(ring_radius) + rnd;
      S_X1: if (!pass) py <= rnd;
      S_Z1: x1 <= rnd;
      S_Y2A: z1 <= rnd;
      S_Z2A: y2 <= rnd;
      S_XA: begin
        if (pass) nm_z <= rnd;
        else pt_z <= rnd + coord_t'(view_distance);
      end
      S_YA: begin
        if (pass) nm_x <= rnd;
        else pt_x <= rnd;
      end
      S_NXT: begin
        if (pass) begin
          nm_y <= rnd;
        end else begin
          pt_y <= rnd;
          px <= coord_t'(req.cos_tube);
          py <= coord_t'(req.sin_tube);
        end
      end
      S_CN1: lum <= rnd + nm_z;
      S_CWAIT: if (div_res.done) col_q <= div_res.quot[CW-1:0];
      S_RWAIT: if (div_res.done) row_q <= div_res.quot[RW-1:0];
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while a request is still in progress");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor answered");

  a_written_sane: assert property (@(posedge clk) disable iff (rst)
    (done && result.written) |-> (!result.dropped && result.shade_code <= SHADE_MAX))
    else $error("written pixel has bad shade or is marked dropped");

  a_dropped_blank: assert property (@(posedge clk) disable iff (rst)
    (done && result.dropped) |-> (result.shade_code == BLANK_CODE))
    else $error("dropped beat carries a shade");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_CWAIT || state == S_RWAIT))
    else $error("divider finished outside a wait state");

endmodule

// File: bench/torus_point_project_zbuffer_tb.sv
// Self-checking bench for the torus point projector with depth buffer.
// Depends on tpz_pkg and torus_point_project_zbuffer; keeps its own frame model
// and predicts each result beat from the requests it hands to the block, or takes it from the directed table.
module torus_point_project_zbuffer_tb;
  import tpz_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int RAND_ITEMS = 1250;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  torus_point_project_zbuffer #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Frame model and register copies.
  logic [3:0]  shade_mem [ROWS*COLS];
  logic [15:0] depth_mem [ROWS*COLS];
  longint cos_tilt, sin_tilt, cos_spin, sin_spin;
  longint tube_radius, ring_radius, view_distance, proj_scale;

  result_t pending_results[$];
  int      errors = 0;
  int      idle_pct = 0;

  // Directed stimulus table.
  request_t dir_req[$];
  bit       dir_typed[$];
  result_t  dir_exp[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint q14_round(longint v);
    return (v + 8192) >>> 14;
  endfunction

  // Ring angle about y, then tilt about x, then spin about z; input z is zero.
  task automatic rotate_vec(input longint px, input longint py, input longint cr,
                            input longint sr, output longint ox, output longint oy,
                            output longint oz);
    longint x1, z1, y2;
    x1 = q14_round(px * cr);
    z1 = q14_round(px * sr);
    y2 = q14_round(py * cos_tilt - z1 * sin_tilt);
    oz = q14_round(py * sin_tilt + z1 * cos_tilt);
    ox = q14_round(x1 * cos_spin - y2 * sin_spin);
    oy = q14_round(x1 * sin_spin + y2 * cos_spin);
  endtask

  task automatic clear_frame();
    for (int i = 0; i < ROWS*COLS; i++) begin
      shade_mem[i] = BLANK_CODE;
      depth_mem[i] = DEPTH_MAX;
    end
  endtask

  task automatic shade_request(input request_t rq, output result_t res);
    longint ct, st, cr, sr, px, py, x, y, z, nx, ny, nz, den, col, row, lum, zq, sh;
    int at;
    res = '0;
    res.shade_code = BLANK_CODE;
    ct = longint'($signed(rq.cos_tube));
    st = longint'($signed(rq.sin_tube));
    cr = longint'($signed(rq.cos_ring));
    sr = longint'($signed(rq.sin_ring));
    case (rq.req_type)
      REQ_CLEAR: clear_frame();
      REQ_READ: begin
        res.pixel_row = rq.read_row;
        res.pixel_col = rq.read_col;
        if (rq.read_row < ROWS && rq.read_col < COLS)
          res.shade_code = shade_mem[int'(rq.read_row) * COLS + int'(rq.read_col)];
        else
          res.dropped = 1'b1;
      end
      REQ_PLOT: begin
        px = ring_radius + q14_round(tube_radius * ct);
        py = q14_round(tube_radius * st);
        rotate_vec(px, py, cr, sr, x, y, z);
        rotate_vec(ct, st, cr, sr, nx, ny, nz);
        z = z + view_distance;
        if (z <= 0) begin
          res.dropped = 1'b1;
        end else begin
          den = z * 256;
          col = (x * proj_scale + (COLS / 2) * den) / den;
          row = (-y * proj_scale + (ROWS / 2) * den) / den;
          if (col < 0 || col >= COLS || row < 0 || row >= ROWS) begin
            res.dropped = 1'b1;
          end else begin
            lum = q14_round((nx + ny) * 11585) + nz;
            zq = (z > 65535) ? 65535 : z;
            at = int'(row) * COLS + int'(col);
            res.pixel_row = row[5:0];
            res.pixel_col = col[5:0];
            if (lum >= 0 && longint'(depth_mem[at]) > zq) begin
              sh = lum / 2048;
              if (sh > 11) sh = 11;
              shade_mem[at] = sh[3:0];
              depth_mem[at] = zq[15:0];
              res.written = 1'b1;
            end
            res.shade_code = shade_mem[at];
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Result beats are taken at the edge that ends their single cycle.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (result.shade_code !== want.shade_code)
          report("shade_code", result.shade_code, want.shade_code);
        if (result.pixel_row !== want.pixel_row)
          report("pixel_row", result.pixel_row, want.pixel_row);
        if (result.pixel_col !== want.pixel_col)
          report("pixel_col", result.pixel_col, want.pixel_col);
        if (result.written !== want.written)
          report("written", result.written, want.written);
        if (result.dropped !== want.dropped)
          report("dropped", result.dropped, want.dropped);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COS_TILT:      cos_tilt = longint'($signed(value));
      REG_SIN_TILT:      sin_tilt = longint'($signed(value));
      REG_COS_SPIN:      cos_spin = longint'($signed(value));
      REG_SIN_SPIN:      sin_spin = longint'($signed(value));
      REG_TUBE_RADIUS:   tube_radius = longint'(value[10:0]);
      REG_RING_RADIUS:   ring_radius = longint'(value[10:0]);
      REG_VIEW_DISTANCE: view_distance = longint'(value[12:0]);
      default:           proj_scale = longint'(value);
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
  endtask

  function automatic request_t noise_req();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    return noise[$bits(request_t)-1:0];
  endfunction

  // Enter at a falling edge, leave at a falling edge with start low.
  task automatic send_request(input request_t rq, input bit typed, input result_t tv);
    result_t pr;
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1'b1;
    request = rq;
    do @(posedge clk); while (busy);
    shade_request(rq, pr);
    pending_results.push_back(typed ? tv : pr);
    @(negedge clk);
    start = 1'b0;
    request = noise_req();
  endtask

  function automatic logic [15:0] q14_trig(input bit use_sin, input real ang);
    real v;
    v = use_sin ? $sin(ang) : $cos(ang);
    return 16'($rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5)));
  endfunction

  function automatic request_t make_req(logic [1:0] kind, int ct, int st, int cr,
                                        int sr, int r, int c);
    request_t rq;
    rq = '{kind, 16'(ct), 16'(st), 16'(cr), 16'(sr), 6'(r), 6'(c)};
    return rq;
  endfunction

  function automatic request_t random_req();
    request_t rq;
    int pick;
    real ta, ra;
    rq = noise_req();
    pick = $urandom_range(999);
    ta = $urandom_range(0, 62831) / 10000.0;
    ra = $urandom_range(0, 62831) / 10000.0;
    if (pick < 15) begin
      rq.req_type = REQ_CLEAR;
    end else if (pick < 35) begin
      rq.req_type = REQ_NONE;
    end else if (pick < 220) begin
      rq.req_type = REQ_READ;
    end else if (pick < 900) begin
      // Well-formed sample: true sine and cosine pairs.
      rq.req_type = REQ_PLOT;
      rq.cos_tube = q14_trig(0, ta);
      rq.sin_tube = q14_trig(1, ta);
      rq.cos_ring = q14_trig(0, ra);
      rq.sin_ring = q14_trig(1, ra);
    end else begin
      rq.req_type = REQ_PLOT;
    end
    return rq;
  endfunction

  task automatic add_row(input request_t rq, input bit typed, input result_t tv);
    dir_req.push_back(rq);
    dir_typed.push_back(typed);
    dir_exp.push_back(tv);
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [15:0] regs [8];
    result_t none;
    real a;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cos_tilt = 16384; sin_tilt = 0; cos_spin = 16384; sin_spin = 0;
    tube_radius = 512; ring_radius = 1024; view_distance = 5120; proj_scale = 16000;
    clear_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block sweeps its frame store after reset.
    do @(posedge clk); while (busy);
    @(negedge clk);

    add_row(make_req(REQ_READ, 0, 0, 0, 0, 0, 0), 1, '{BLANK_CODE, 0, 0, 0, 0});
    add_row(make_req(REQ_READ, 0, 0, 0, 0, 63, 63), 1, '{BLANK_CODE, 63, 63, 0, 0});
    add_row(make_req(REQ_NONE, 16'h7FFF, 16'h8000, 16'hFFFF, 1, 63, 63), 1,
            '{BLANK_CODE, 0, 0, 0, 0});
    for (int k = 0; k < 8; k++) begin
      a = k * 0.785398;
      add_row(make_req(REQ_PLOT, q14_trig(0, a), q14_trig(1, a),
                       q14_trig(0, a * 2.0), q14_trig(1, a * 2.0), 0, 0), 0, none);
    end
    add_row(make_req(REQ_PLOT, 16384, 0, 16384, 0, 0, 0), 0, none);
    add_row(make_req(REQ_PLOT, -16384, 0, -16384, 0, 0, 0), 0, none);
    add_row(make_req(REQ_PLOT, 0, 16384, 0, 16384, 0, 0), 0, none);
    add_row(make_req(REQ_PLOT, 0, -16384, 0, -16384, 0, 0), 0, none);
    // Out-of-range magnitudes push the shade past the ramp.
    add_row(make_req(REQ_PLOT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 0, 0), 0, none);
    add_row(make_req(REQ_PLOT, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 0), 0, none);
    add_row(make_req(REQ_PLOT, 16384, 0, 16384, 0, 0, 0), 0, none);
    add_row(make_req(REQ_READ, 0, 0, 0, 0, 32, 40), 0, none);
    add_row(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 1, '{BLANK_CODE, 0, 0, 0, 0});
    add_row(make_req(REQ_READ, 0, 0, 0, 0, 32, 40), 1, '{BLANK_CODE, 32, 40, 0, 0});

    regs = '{16384, 0, 16384, 0, 512, 1024, 5120, 16000};
    write_all(regs);
    for (int i = 0; i < dir_req.size(); i++)
      send_request(dir_req[i], dir_typed[i], dir_exp[i]);

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        1: regs = '{16'hC000, 16384, 16'hC000, 16384, 2047, 2047, 0, 65535};
        2: regs = '{16384, 16'hC000, 16384, 16'hC000, 0, 0, 8191, 0};
        default: begin
          a = $urandom_range(0, 62831) / 10000.0;
          regs[0] = q14_trig(0, a);
          regs[1] = q14_trig(1, a);
          a = $urandom_range(0, 62831) / 10000.0;
          regs[2] = q14_trig(0, a);
          regs[3] = q14_trig(1, a);
          regs[4] = 16'($urandom_range(128, 800));
          regs[5] = 16'($urandom_range(400, 1600));
          regs[6] = 16'($urandom_range(ph == 5 ? 0 : 2500, 8191));
          regs[7] = 16'($urandom_range(4000, ph == 6 ? 65535 : 24000));
        end
      endcase
      write_all(regs);
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 56 : 18);
      for (int n = 0; n < RAND_ITEMS / 7; n++)
        send_request(random_req(), 0, none);
    end

    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: torus_point_project_zbuffer.f
src/tpz_pkg.sv
src/tpz_mac.sv
src/tpz_div.sv
src/torus_point_project_zbuffer.sv
bench/torus_point_project_zbuffer_tb.sv
